@@ rtl/efb_pkg.sv @@
// efb_pkg: shared constants for the Ethernet frame builder with CRC-32 FCS.
// Used by efb_crc32 and ethernet_frame_builder_crc32_unit; no dependencies.

package efb_pkg;

   // Reflected CRC-32 (IEEE 802.3 FCS)
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Header layout
   localparam int          HDR_LEN  = 14;
   localparam int          HDR_BITS = HDR_LEN * 8;
   localparam int          FCS_LEN  = 4;

   // Register widths and reset values
   localparam int          MAC_W    = 48;
   localparam int          ETYPE_W  = 16;
   localparam int          CSR_IDX_W = 2;
   localparam logic [MAC_W-1:0]   DEST_MAC_RST   = 48'h3DE1_2D6F_E934;
   localparam logic [MAC_W-1:0]   SRC_MAC_RST    = 48'h34E1_2D6F_E93D;
   localparam logic [ETYPE_W-1:0] ETHER_TYPE_RST = 16'h0800;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_MAC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_MAC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ETHER_TYPE = 2'd2;

   // Control from the sequencer to the CRC unit
   typedef struct packed {
      logic step;     // fold one byte into the running CRC
      logic restart;  // start from CRC_INIT instead of the stored value
   } crc_ctrl_type;

endpackage

@@ rtl/efb_crc32.sv @@
// efb_crc32: running reflected CRC-32 register with a byte-wide update.
// Depends on efb_pkg for the polynomial, initial value and control struct.

module efb_crc32 (
   input  logic                 clock,
   input  logic                 reset,
   input  efb_pkg::crc_ctrl_type ctrl,
   input  logic [7:0]           data_byte,
   output logic [31:0]          crc
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] crc_base;
   logic [31:0] crc_upd;

   // Eight bit steps of the reflected shift register, unrolled into an XOR net
   always_comb begin
      crc_upd = crc_base ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (crc_upd[0]) begin
            crc_upd = (crc_upd >> 1) ^ efb_pkg::CRC_POLY;
         end else begin
            crc_upd = crc_upd >> 1;
         end
      end
   end

   assign crc_base = ctrl.restart ? efb_pkg::CRC_INIT : crc_ff;
   assign crc_in   = ctrl.step ? crc_upd : crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= efb_pkg::CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

@@ rtl/ethernet_frame_builder_crc32_unit.sv @@
// ethernet_frame_builder_crc32_unit: top level of the Ethernet frame builder.
// Depends on efb_pkg and efb_crc32.
//
// Usage:
//   req_* carries payload words (one byte plus a last flag) under valid/ready.
//   rsp_* carries frame words (one byte plus frame_end) under valid/ready.
//   csr_* is a plain write port: csr_we writes csr_wdata into register
//   csr_index (0 dest MAC, 1 source MAC, 2 EtherType); other indexes drop.
//   Write registers only while no frame is open; the header is read from
//   them as it is sent.
// Flow:
//   The first payload word of a frame produces the 14-byte header (dest MAC,
//   source MAC, EtherType, each MSB first), then the payload byte. A word
//   flagged last is followed by the 4 FCS bytes, LSB first, frame_end on the
//   final one. The CRC-32 covers header and payload.
// Timing:
//   One holding register for the input word, one output register for the
//   frame word; frame words reach rsp through the output register.
//   Throughput is one frame word per cycle while rsp_ready is high, set by
//   the single output register.
// Reset and stall:
//   Reset empties both registers, closes any open frame, restores register
//   defaults. While rsp_valid is high and rsp_ready low, the output word holds
//   and the sequencer waits; req_ready is low while a held word is unfinished.

module ethernet_frame_builder_crc32_unit (
   input  logic                          clock,
   input  logic                          reset,
   // payload input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_payload_byte,
   input  logic                          req_last_byte,
   // frame output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_frame_end,
   // configuration
   input  logic                          csr_we,
   input  logic [efb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efb_pkg::MAC_W-1:0]     csr_wdata
);

   // Sequencer phases
   localparam logic [1:0] PH_HDR  = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_FCS  = 2'd2;
   localparam logic [3:0] HDR_IDX_LAST = 4'(efb_pkg::HDR_LEN - 1);
   localparam logic [3:0] FCS_IDX_LAST = 4'(efb_pkg::FCS_LEN - 1);

   // Configuration registers
   logic [efb_pkg::MAC_W-1:0]   dest_mac_ff, dest_mac_in;
   logic [efb_pkg::MAC_W-1:0]   src_mac_ff, src_mac_in;
   logic [efb_pkg::ETYPE_W-1:0] ether_type_ff, ether_type_in;

   // Holding register for the current input word
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       hold_last_ff, hold_last_in;

   // Sequencer
   logic [1:0] phase_ff, phase_in;
   logic [3:0] idx_ff, idx_in;
   logic       in_frame_ff, in_frame_in;

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;

   logic                         out_free;
   logic                         step;
   logic                         word_done;
   logic                         req_take;
   logic [7:0]                   seq_byte;
   logic                         seq_end;
   logic                         seq_done;
   logic [efb_pkg::HDR_BITS-1:0] hdr_vec;
   logic [efb_pkg::HDR_BITS-1:0] hdr_shift;
   logic [31:0]                  crc;
   logic [31:0]                  fcs_shift;
   efb_pkg::crc_ctrl_type        crc_ctrl;

   // ---------------- configuration ----------------
   always_comb begin
      dest_mac_in   = dest_mac_ff;
      src_mac_in    = src_mac_ff;
      ether_type_in = ether_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            efb_pkg::CSR_DEST_MAC:   dest_mac_in   = csr_wdata;
            efb_pkg::CSR_SRC_MAC:    src_mac_in    = csr_wdata;
            efb_pkg::CSR_ETHER_TYPE: ether_type_in = csr_wdata[efb_pkg::ETYPE_W-1:0];
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // ---------------- byte selection ----------------
   assign hdr_vec   = {dest_mac_ff, src_mac_ff, ether_type_ff};
   assign hdr_shift = hdr_vec << {idx_ff, 3'b000};
   assign fcs_shift = (~crc) >> {idx_ff[1:0], 3'b000};

   // Advance whenever a word is held and the output register can take a byte
   assign out_free = !out_valid_ff || rsp_ready;
   assign step     = hold_valid_ff && out_free;

   always_comb begin
      seq_byte         = 8'd0;
      seq_end          = 1'b0;
      seq_done         = 1'b0;
      crc_ctrl.step    = 1'b0;
      crc_ctrl.restart = 1'b0;
      unique case (phase_ff)
         PH_HDR: begin
            seq_byte         = hdr_shift[efb_pkg::HDR_BITS-1 -: 8];
            crc_ctrl.step    = step;
            crc_ctrl.restart = (idx_ff == 4'd0);
         end
         PH_DATA: begin
            seq_byte      = hold_byte_ff;
            crc_ctrl.step = step;
            seq_done      = !hold_last_ff;
         end
         PH_FCS: begin
            seq_byte = fcs_shift[7:0];
            seq_end  = (idx_ff == FCS_IDX_LAST);
            seq_done = seq_end;
         end
         default: ;
      endcase
   end

   assign word_done = step && seq_done;
   assign req_ready = !hold_valid_ff || word_done;
   assign req_take  = req_valid && req_ready;

   // ---------------- sequencer and holding register ----------------
   always_comb begin
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      in_frame_in   = in_frame_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_last_in  = hold_last_ff;

      if (step) begin
         unique case (phase_ff)
            PH_HDR: begin
               if (idx_ff == HDR_IDX_LAST) begin
                  phase_in    = PH_DATA;
                  idx_in      = 4'd0;
                  in_frame_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            PH_DATA: begin
               if (hold_last_ff) begin
                  phase_in = PH_FCS;
                  idx_in   = 4'd0;
               end
            end
            PH_FCS: begin
               idx_in = idx_ff + 4'd1;
               if (seq_end) begin
                  in_frame_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (word_done) begin
         hold_valid_in = 1'b0;
      end

      // Load a new word; an open frame skips the header
      if (req_take) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = req_payload_byte;
         hold_last_in  = req_last_byte;
         phase_in      = in_frame_in ? PH_DATA : PH_HDR;
         idx_in        = 4'd0;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = seq_byte;
         out_end_in   = seq_end;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_mac_ff   <= efb_pkg::DEST_MAC_RST;
         src_mac_ff    <= efb_pkg::SRC_MAC_RST;
         ether_type_ff <= efb_pkg::ETHER_TYPE_RST;
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_HDR;
         idx_ff        <= 4'd0;
         in_frame_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         dest_mac_ff   <= dest_mac_in;
         src_mac_ff    <= src_mac_in;
         ether_type_ff <= ether_type_in;
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         in_frame_ff   <= in_frame_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_last_ff <= hold_last_in;
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
   end

   efb_crc32 u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .data_byte (seq_byte),
      .crc       (crc)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = out_end_ff;

endmodule

@@ rtl/efb_checker.sv @@
// efb_checker: port-level assertions for ethernet_frame_builder_crc32_unit.
// Depends on the top level's port list; bound to it at the end of this file.

module efb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_frame_end
);

   // Every frame carries header, at least one payload byte and FCS
   localparam logic [4:0] MIN_WORDS_BEFORE_END = 5'd18;

   logic [4:0] words_ff, words_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      words_in = words_ff;
      if (rsp_take) begin
         if (rsp_frame_end) begin
            words_in = 5'd0;
         end else if (words_ff != 5'd31) begin
            words_in = words_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= 5'd0;
      end else begin
         words_ff <= words_in;
      end
   end

   // Hold a stalled word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_frame_end))
      else $error("stalled output word changed");

   // Drop any pending word on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // Frame end only after a full header, payload and the first FCS bytes
   a_min_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_frame_end |-> words_ff >= MIN_WORDS_BEFORE_END)
      else $error("frame shorter than header plus FCS");

   // Input stalls only while output is blocked or the held word is busy
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(!req_valid) && !$past(reset)
      |-> req_ready)
      else $error("input stalled with empty pipeline");

endmodule

bind ethernet_frame_builder_crc32_unit efb_checker u_efb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_frame_end (rsp_frame_end)
);

@@ test/tb_ethernet_frame_builder_crc32_unit.sv @@
// Self-checking testbench for ethernet_frame_builder_crc32_unit: header insertion, payload
// pass-through and CRC-32 FCS append, checked word by word against an in-bench predictor.
// Depends on efb_pkg and the RTL of the frame builder; needs no files or arguments.

module tb_ethernet_frame_builder_crc32_unit;
   import efb_pkg::*;

   // Index with no register behind it; writes to it must drop.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 75;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } payload_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       frame_end;
   } frame_word_type;

   // Clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Block ports, all driven to known values from time zero
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_payload_byte = 8'd0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_frame_end;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEST_MAC;
   logic [MAC_W-1:0]     csr_wdata = '0;

   ethernet_frame_builder_crc32_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Stimulus and expectation stores
   payload_word_type payload_queue[$];
   frame_word_type   frame_due[$];
   payload_word_type next_word;
   frame_word_type   got_word;
   frame_word_type   want_word;

   // Predictor copy of the header registers and the frame state
   logic [MAC_W-1:0]   hdr_dest  = DEST_MAC_RST;
   logic [MAC_W-1:0]   hdr_src   = SRC_MAC_RST;
   logic [ETYPE_W-1:0] hdr_etype = ETHER_TYPE_RST;
   logic [31:0]        crc_run   = CRC_INIT;
   logic               frame_open = 1'b0;

   // Flow control bookkeeping
   logic req_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   logic steady = 1'b0;     // no idling on either side in the closing part
   int   cycle_count = 0;
   int   mismatches = 0;

   // Fold one byte into the reflected CRC-32, LSB first.
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Queue a covered frame byte (header or payload) and advance the CRC over it.
   function automatic void push_covered(input logic [7:0] b);
      frame_due.push_back(frame_word_type'{data: b, frame_end: 1'b0});
      crc_run = crc_fold(crc_run, b);
   endfunction

   // Work out every frame word caused by one accepted payload word.
   function automatic void build_frame_words(input logic [7:0] pb, input logic last);
      logic [31:0] fcs;
      // Opening word of a frame: header goes out first, taken from the registers now.
      if (!frame_open) begin
         crc_run = CRC_INIT;
         for (int i = 5; i >= 0; i--) push_covered(hdr_dest[8*i +: 8]);
         for (int i = 5; i >= 0; i--) push_covered(hdr_src[8*i +: 8]);
         push_covered(hdr_etype[15:8]);
         push_covered(hdr_etype[7:0]);
         frame_open = 1'b1;
      end
      push_covered(pb);
      // Closing word: append the inverted CRC, LSB first, mark the final byte.
      if (last) begin
         fcs = ~crc_run;
         for (int i = 0; i < FCS_LEN; i++) begin
            frame_due.push_back(frame_word_type'{data: fcs[8*i +: 8],
                                                 frame_end: (i == FCS_LEN - 1)});
         end
         crc_run = CRC_INIT;
         frame_open = 1'b0;
      end
   endfunction

   function automatic void report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                  cycle_count, what, want, got);
      end
   endfunction

   // Input side: record accepted words, predict their frame words, watch the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         build_frame_words(req_payload_byte, req_last_byte);
      end
   end

   // Driver: hold a word until taken, then idle in bursts or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the word and its payload until the handshake
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         req_gap <= $urandom_range(0, 15);
      end else if (payload_queue.size() > 0) begin
         next_word = payload_queue.pop_front();
         req_valid <= 1'b1;
         req_payload_byte <= next_word.data;
         req_last_byte <= next_word.last;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall in random bursts so back-pressure lands on header, payload and FCS.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (!steady && $urandom_range(0, 11) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compare each accepted frame word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = frame_word_type'{data: rsp_out_byte, frame_end: rsp_frame_end};
         if (frame_due.size() == 0) begin
            report_mismatch("unexpected word", 0, int'(got_word));
         end else begin
            want_word = frame_due.pop_front();
            if (got_word.data !== want_word.data)
               report_mismatch("out_byte", int'(want_word.data), int'(got_word.data));
            if (got_word.frame_end !== want_word.frame_end)
               report_mismatch("frame_end", int'(want_word.frame_end),
                               int'(got_word.frame_end));
         end
      end
   end

   // Write one register at the next falling edge; mirror it into the predictor.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MAC_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DEST_MAC:   hdr_dest = value;
         CSR_SRC_MAC:    hdr_src = value;
         CSR_ETHER_TYPE: hdr_etype = value[ETYPE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_word(input logic [7:0] b, input logic last);
      payload_queue.push_back(payload_word_type'{data: b, last: last});
   endtask

   // Block until every word is taken and every frame word has come back.
   task automatic drain();
      while (payload_queue.size() != 0 || req_valid || frame_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [MAC_W-1:0] pick_value(input int width);
      logic [MAC_W-1:0] v;
      case ($urandom_range(0, 3))
         0:       v = '0;
         1:       v = '1;
         default: v = {16'($urandom), 32'($urandom)};
      endcase
      if (width < MAC_W) v = v & ((48'd1 << width) - 1);
      return v;
   endfunction

   // Reprogram the header with random values, extremes included.
   task automatic shuffle_header();
      logic [MAC_W-1:0] etype_pick;
      write_reg(CSR_DEST_MAC, pick_value(MAC_W));
      write_reg(CSR_SRC_MAC, pick_value(MAC_W));
      // spare upper bits of the data bus must drop on the EtherType write
      etype_pick = pick_value(ETYPE_W);
      write_reg(CSR_ETHER_TYPE, {16'($urandom), 16'($urandom), etype_pick[15:0]});
      if ($urandom_range(0, 2) == 0) write_reg(CSR_SPARE_IDX, {16'($urandom), 32'($urandom)});
      end_writes();
   endtask

   // Queue whole frames worth exactly n words; the phase always closes its frame.
   task automatic queue_frames(input int n);
      int remaining;
      int len;
      remaining = n;
      while (remaining > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
         if (len > remaining) len = remaining;
         for (int i = 0; i < len; i++) queue_word(8'($urandom), i == len - 1);
         remaining -= len;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset header: one-byte frames at both byte extremes, then a short frame.
      queue_word(8'h00, 1'b1);
      queue_word(8'hFF, 1'b1);
      queue_word(8'h80, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h7F, 1'b1);
      drain();

      // All-ones destination, zero source, all-ones EtherType with junk above; spare index drops.
      write_reg(CSR_DEST_MAC, '1);
      write_reg(CSR_SRC_MAC, '0);
      write_reg(CSR_ETHER_TYPE, {32'hA5C3_5A3C, 16'hFFFF});
      write_reg(CSR_SPARE_IDX, 48'h1234_5678_9ABC);
      end_writes();
      queue_word(8'h55, 1'b1);
      queue_word(8'hAA, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b1);
      drain();

      // Mirror the extremes: zero destination, all-ones source, zero EtherType.
      write_reg(CSR_DEST_MAC, '0);
      write_reg(CSR_SRC_MAC, '1);
      write_reg(CSR_ETHER_TYPE, {32'hFFFF_FFFF, 16'h0000});
      end_writes();
      queue_word(8'h00, 1'b1);
      queue_word(8'hFF, 1'b0);
      queue_word(8'hFF, 1'b1);
      drain();

      // Random phases with a fresh header each time; the last runs without idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         shuffle_header();
         if (p == RANDOM_PHASES - 1) steady = 1'b1;
         queue_frames(PHASE_WORDS);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && frame_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
